// File: design/bounded_byte_stream_fifo_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded byte stream FIFO
// Shared property shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_BYTE_STREAM_FIFO_UNIT_MACROS_SVH
`define BOUNDED_BYTE_STREAM_FIFO_UNIT_MACROS_SVH

// same-cycle implication
`define BBSF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbsf assertion failed");

// next-cycle implication
`define BBSF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbsf assertion failed");

`endif

// File: design/bbsf_pkg.sv
// ----------------------------------------------------------------------------
// bbsf_pkg
// Types, constants and helpers shared by the bounded byte stream FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package bbsf_pkg;

   localparam int DEPTH     = 1024;
   localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = 11;
   localparam int SUM_W     = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
   localparam int TOT_W     = 64;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 168;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLOSE = 2'd2
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic [PTR_W-1:0] rd_addr;
   } store_req_type;

   // ring advance by n, n never above DEPTH
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] n);
      logic [SUM_W-1:0] s;
      s = SUM_W'(ptr) + SUM_W'(n);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return PTR_W'(s);
   endfunction

endpackage

`default_nettype wire

// File: design/bbsf_store.sv
// ----------------------------------------------------------------------------
// bbsf_store
// Byte ring store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbsf_store (
   input  wire logic                   clock,
   input  wire bbsf_pkg::store_req_type store_req,
   output logic [7:0]                  rd_data
);

   logic [7:0] mem [bbsf_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[store_req.rd_addr];
   end

endmodule

`default_nettype wire

// File: design/bbsf_ctrl.sv
// ----------------------------------------------------------------------------
// bbsf_ctrl
// Pointers, counts and flags; issues store accesses and builds each result.
// ----------------------------------------------------------------------------
`default_nettype none

module bbsf_ctrl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [bbsf_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire logic [1:0]                            req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [bbsf_pkg::RSP_DATA_W-1:0]            rsp_tdata,
   input  wire logic                                  csr_wr_en,
   input  wire logic [bbsf_pkg::CNT_W-1:0]            csr_wr_data,
   output bbsf_pkg::store_req_type                    store_req,
   input  wire logic [7:0]                            rd_data
);

   bbsf_pkg::state_type state_ff, state_in;

   logic [bbsf_pkg::PTR_W-1:0] rp_ff, rp_in;
   logic [bbsf_pkg::PTR_W-1:0] wp_ff, wp_in;
   logic [bbsf_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic [bbsf_pkg::TOT_W-1:0] popped_ff, popped_in;
   logic                       closed_ff, closed_in;
   logic [bbsf_pkg::CNT_W-1:0] cap_ff, cap_in;
   logic                       acc_ff, acc_in;
   logic                       fwd_ff, fwd_in;
   logic [7:0]                 fwd_data_ff, fwd_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bbsf_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                       req_fire;
   logic                       load_rsp;
   logic [bbsf_pkg::CNT_W-1:0] cap_eff;
   logic [bbsf_pkg::CNT_W-1:0] pop_n;
   logic [bbsf_pkg::CNT_W-1:0] room;
   logic [7:0]                 front;
   logic [bbsf_pkg::TOT_W-1:0] pushed_total;
   logic [7:0]                 data_byte;
   logic [bbsf_pkg::CNT_W-1:0] pop_length;

   assign data_byte  = req_tdata[7:0];
   assign pop_length = req_tdata[18:8];
   assign req_fire   = req_tvalid & req_tready;

   assign cap_eff = (32'(cap_ff) > 32'(bbsf_pkg::DEPTH)) ?
                    bbsf_pkg::CNT_W'(bbsf_pkg::DEPTH) : cap_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbsf_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = bbsf_pkg::ST_READ;
            end
         end
         bbsf_pkg::ST_READ: begin
            state_in = bbsf_pkg::ST_IDLE;
         end
         default: state_in = bbsf_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         bbsf_pkg::ST_IDLE: req_tready = ~rsp_valid_ff | rsp_tready;
         bbsf_pkg::ST_READ: load_rsp   = 1'b1;
         default: begin
            req_tready = 1'b0;
            load_rsp   = 1'b0;
         end
      endcase
   end

   // operation update
   always_comb begin
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      fill_in     = fill_ff;
      popped_in   = popped_ff;
      closed_in   = closed_ff;
      acc_in      = acc_ff;
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      pop_n       = (pop_length > fill_ff) ? fill_ff : pop_length;
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = wp_ff;
      store_req.wr_data = data_byte;
      if (req_fire) begin
         acc_in      = 1'b0;
         fwd_in      = 1'b0;
         fwd_data_in = data_byte;
         case (bbsf_pkg::op_type'(req_tuser))
            bbsf_pkg::OP_PUSH: begin
               if (fill_ff < cap_eff) begin
                  store_req.wr_en = 1'b1;
                  wp_in   = bbsf_pkg::advance(wp_ff, bbsf_pkg::CNT_W'(1));
                  fill_in = fill_ff + bbsf_pkg::CNT_W'(1);
                  acc_in  = 1'b1;
                  fwd_in  = (fill_ff == '0);
               end
            end
            bbsf_pkg::OP_POP: begin
               rp_in     = bbsf_pkg::advance(rp_ff, pop_n);
               fill_in   = fill_ff - pop_n;
               popped_in = popped_ff + bbsf_pkg::TOT_W'(pop_n);
            end
            bbsf_pkg::OP_CLOSE: closed_in = 1'b1;
            default: ;
         endcase
      end
      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end else begin
         cap_in = cap_ff;
      end
      store_req.rd_addr = rp_in;
   end

   // result assembly
   always_comb begin
      room         = (cap_eff > fill_ff) ? (cap_eff - fill_ff) : '0;
      front        = (fill_ff == '0) ? 8'd0 : (fwd_ff ? fwd_data_ff : rd_data);
      pushed_total = popped_ff + bbsf_pkg::TOT_W'(fill_ff);
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0,
                         closed_ff & (fill_ff == '0),
                         closed_ff,
                         popped_ff,
                         pushed_total,
                         room,
                         fill_ff,
                         front,
                         (fill_ff != '0),
                         acc_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbsf_pkg::ST_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         popped_ff    <= '0;
         closed_ff    <= 1'b0;
         cap_ff       <= bbsf_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         popped_ff    <= popped_in;
         closed_ff    <= closed_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= fwd_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: design/bounded_byte_stream_fifo_unit.sv
// Flow: an accepted item moves the control into its read state, where the
//   store's registered front-byte read is available and the result register
//   loads; input waits meanwhile, and a stalled result holds off input.
// Reset: synchronous, active high; clears pointers, counts, totals, the
//   closed flag and the result valid flag, and sets capacity to 1024.
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo_unit
// Bounded byte FIFO with writer close: push, pop and close items in, one
// status item out for each.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_byte_stream_fifo_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [7:0] data_byte, [18:8] pop_length, [23:19] zero
   input  wire logic [bbsf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] opcode
   input  wire logic [1:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] accepted, [1] front_valid, [9:2] front_byte, [20:10] buffered_count,
   // [31:21] available_room, [95:32] total_pushed, [159:96] total_popped,
   // [160] writer_closed, [161] stream_finished, [167:162] zero
   output logic [bbsf_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                             csr_wr_en,
   input  wire logic [bbsf_pkg::CNT_W-1:0]       csr_wr_data
);

   bbsf_pkg::store_req_type store_req;
   logic [7:0]              rd_data;

   bbsf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .store_req   (store_req),
      .rd_data     (rd_data)
   );

   bbsf_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

endmodule

`default_nettype wire

// File: design/bbsf_checker.sv
// ----------------------------------------------------------------------------
// bbsf_checker
// Port-level checks for the bounded byte stream FIFO, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_byte_stream_fifo_unit_macros.svh"

module bbsf_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [bbsf_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic req_fire;
   assign req_fire = req_tvalid & req_tready;

   `BBSF_ASSERT_NXT(a_one_at_a_time, clock, reset, req_fire, !req_tready)
   `BBSF_ASSERT_NXT(a_result_follows, clock, reset, req_fire, ##1 rsp_tvalid)
   `BBSF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `BBSF_ASSERT_IMP(a_finished_empty, clock, reset, rsp_tvalid && rsp_tdata[161], rsp_tdata[160] && rsp_tdata[20:10] == 11'd0 && !rsp_tdata[1])
   `BBSF_ASSERT_IMP(a_accept_front, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[1] && rsp_tdata[20:10] != 11'd0)

endmodule

bind bounded_byte_stream_fifo_unit bbsf_checker u_bbsf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded byte stream FIFO. A shadow of the ring
// store, counts, totals and closed flag predicts the status item for every
// push, pop, close and unused opcode. Directed items cover the edge cases,
// then random phases run under several capacities with random stalls on both
// sides and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import bbsf_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      bit             accepted;
      bit             front_valid;
      bit [7:0]       front_byte;
      bit [CNT_W-1:0] buffered;
      bit [CNT_W-1:0] room;
      bit [TOT_W-1:0] pushed;
      bit [TOT_W-1:0] popped;
      bit             closed;
      bit             finished;
   } fifo_status_type;

   class byte_fifo_shadow;
      bit [7:0]        store [DEPTH];
      bit [PTR_W-1:0]  rd_ptr;
      bit [PTR_W-1:0]  wr_ptr;
      bit [CNT_W-1:0]  fill;
      bit [CNT_W-1:0]  capacity;
      bit [TOT_W-1:0]  popped;
      bit              closed;
      fifo_status_type status_due [$];
      int              errors;
      int              checked;
      int              stored;
      int              peak_fill;
      int              wraps;

      function new();
         capacity = CAP_RESET;
      endfunction

      function void note_item(logic [1:0] op, logic [7:0] data, logic [CNT_W-1:0] len);
         bit [CNT_W-1:0]  cap;
         bit [CNT_W-1:0]  n;
         fifo_status_type s;
         cap = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
         s.accepted = 1'b0;
         case (op)
            OP_PUSH: begin
               if (fill < cap) begin
                  store[wr_ptr] = data;
                  wr_ptr = PTR_W'((int'(wr_ptr) + 1) % DEPTH);
                  if (wr_ptr == '0) begin
                     wraps++;
                  end
                  fill++;
                  stored++;
                  s.accepted = 1'b1;
               end
            end
            OP_POP: begin
               n = (len > fill) ? fill : len;
               rd_ptr = PTR_W'((int'(rd_ptr) + int'(n)) % DEPTH);
               fill -= n;
               popped += TOT_W'(n);
            end
            OP_CLOSE: begin
               closed = 1'b1;
            end
            default: begin
            end
         endcase
         if (int'(fill) > peak_fill) begin
            peak_fill = int'(fill);
         end
         s.front_valid = (fill != 0);
         s.front_byte  = (fill != 0) ? store[rd_ptr] : 8'h00;
         s.buffered    = fill;
         s.room        = (cap > fill) ? cap - fill : '0;
         s.pushed      = popped + TOT_W'(fill);
         s.popped      = popped;
         s.closed      = closed;
         s.finished    = closed && (fill == 0);
         status_due.insert(status_due.size(), s);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) begin
            $display("tb_top: status item %0d at %0t: %s", checked, $realtime, what);
         end
      endtask

      task compare_field(string name, logic [63:0] got, bit [63:0] want);
         if (got !== want) begin
            report($sformatf("%s got %0h expected %0h", name, got, want));
         end
      endtask

      task check_status(logic [RSP_DATA_W-1:0] d);
         fifo_status_type s;
         checked++;
         if (status_due.size() == 0) begin
            report("status item with none expected");
         end else begin
            s = status_due[0];
            status_due.delete(0);
            compare_field("accepted", 64'(d[0]), 64'(s.accepted));
            compare_field("front_valid", 64'(d[1]), 64'(s.front_valid));
            compare_field("front_byte", 64'(d[9:2]), 64'(s.front_byte));
            compare_field("buffered_count", 64'(d[20:10]), 64'(s.buffered));
            compare_field("available_room", 64'(d[31:21]), 64'(s.room));
            compare_field("total_pushed", d[95:32], s.pushed);
            compare_field("total_popped", d[159:96], s.popped);
            compare_field("writer_closed", 64'(d[160]), 64'(s.closed));
            compare_field("stream_finished", 64'(d[161]), 64'(s.finished));
            compare_field("padding", 64'(d[167:162]), '0);
         end
      endtask
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [1:0]            req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data = '0;

   byte_fifo_shadow board;
   int send_gap_max = 3;
   int recv_gap_max = 3;
   bit hold_request = 1'b0;
   int items_sent   = 0;
   int idle_cycles  = 0;

   bounded_byte_stream_fifo_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_status(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            board.note_item(req_tuser, req_tdata[7:0], req_tdata[CNT_W+7:8]);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   initial begin : drain_results
      int gap;
      forever begin
         gap = $urandom_range(recv_gap_max, 0);
         if (hold_request) begin
            gap = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                            input logic [CNT_W-1:0] len);
      int gap;
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({len, data});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // wait for every status item, let the block settle, then write capacity
   task automatic set_capacity(input logic [CNT_W-1:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.status_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.capacity = value;
   endtask

   task automatic random_phase(input int count, input int push_pct, input int pop_pct);
      int          pick;
      logic [1:0]  op;
      logic [7:0]  data;
      logic [CNT_W-1:0] len;
      repeat (count) begin
         pick = $urandom_range(99, 0);
         data = 8'($urandom);
         len  = CNT_W'($urandom);
         if (pick < push_pct) begin
            op = OP_PUSH;
         end else if (pick < push_pct + pop_pct) begin
            op = OP_POP;
            if ($urandom_range(9, 0) != 0) begin
               len = CNT_W'($urandom_range(6, 0));
            end
         end else begin
            op = ($urandom_range(1, 0) != 0) ? OP_CLOSE : OP_NONE;
         end
         send_item(op, data, len);
      end
   endtask

   initial begin
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_capacity(4);
      send_item(OP_PUSH, 8'h00, 0);
      send_item(OP_PUSH, 8'hFF, 0);
      send_item(OP_PUSH, 8'hA5, 0);
      send_item(OP_PUSH, 8'h5A, 0);
      send_item(OP_PUSH, 8'h11, 0);
      send_item(OP_POP, 8'h00, 0);
      send_item(OP_POP, 8'h00, 1);
      send_item(OP_NONE, 8'hFF, 11'h7FF);
      send_item(OP_CLOSE, 8'h00, 0);
      send_item(OP_CLOSE, 8'hFF, 11'h7FF);
      send_item(OP_PUSH, 8'h3C, 0);
      send_item(OP_POP, 8'h00, 11'h7FF);
      send_item(OP_POP, 8'h00, 1);
      send_item(OP_PUSH, 8'h7E, 0);
      set_capacity(0);
      send_item(OP_PUSH, 8'h01, 0);
      send_item(OP_POP, 8'h00, 1);
      send_item(OP_PUSH, 8'h02, 0);
      set_capacity(11'h7FF);
      send_item(OP_PUSH, 8'h80, 0);
      send_item(OP_PUSH, 8'h7F, 0);
      send_item(OP_POP, 8'h00, 11'd1024);
      send_item(OP_POP, 8'h00, 0);

      // fill deep while results are held off
      set_capacity(CNT_W'(DEPTH));
      send_gap_max = 0;
      recv_gap_max = 15;
      hold_request = 1'b1;
      random_phase(500, 92, 6);

      // capacity below the fill level
      set_capacity(16);
      send_gap_max = 15;
      recv_gap_max = 15;
      random_phase(100, 40, 50);

      set_capacity(11'h7FF);
      send_gap_max = 0;
      recv_gap_max = 0;
      random_phase(200, 80, 15);

      set_capacity(1);
      send_gap_max = 15;
      recv_gap_max = 0;
      random_phase(60, 50, 40);

      repeat (3) begin
         set_capacity(CNT_W'($urandom_range(40, 2)));
         send_gap_max = $urandom_range(15, 0);
         recv_gap_max = $urandom_range(15, 0);
         random_phase(40, 60, 35);
      end

      set_capacity(0);
      random_phase(20, 60, 30);

      set_capacity(CNT_W'($urandom_range(2047, 0)));
      send_gap_max = 15;
      recv_gap_max = 15;
      random_phase(80, 65, 30);

      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.status_due.size() != 0);
      repeat (8) @(posedge clock);

      $display("tb_top: %0d items sent, %0d status items checked, %0d bytes stored",
               items_sent, board.checked, board.stored);
      $display("tb_top: peak fill %0d bytes, write pointer wrapped %0d times",
               board.peak_fill, board.wraps);
      if (board.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// File: bounded_byte_stream_fifo_unit.f
+incdir+design
design/bbsf_pkg.sv
design/bbsf_store.sv
design/bbsf_ctrl.sv
design/bounded_byte_stream_fifo_unit.sv
design/bbsf_checker.sv
sim/tb_top.sv
